>>> rtl/core/jsr_pkg.sv
package jsr_pkg;

  // Default line buffer depth (columns, boundary included)
  localparam int MAX_WIDTH_DEF = 1024;
  // Width of grid values
  localparam int VALUE_BITS = 32;
  // Residual accumulator width
  localparam int ACC_BITS = 63;

  localparam logic signed [63:0] ONE_Q24 = 64'sd16777216;
  localparam logic [47:0] COEF_LIM = 48'hFFFF_FFFF_FFFF;
  localparam logic [46:0] NCC_LIM = 47'h7FFF_FFFF_FFFF;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_X_START     = 3'd2,
    REG_Y_START     = 3'd3,
    REG_DELTA_X     = 3'd4,
    REG_DELTA_Y     = 3'd5,
    REG_ALPHA       = 3'd6,
    REG_OMEGA       = 3'd7
  } cfg_reg_t;

  // Fraction bits dropped after a product
  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_24 = 2'd1,
    SH_35 = 2'd2
  } mul_shift_t;

  // Magnitude limit of a product
  typedef enum logic [1:0] {
    LIM_Q32 = 2'd0,
    LIM_BIG = 2'd1,
    LIM_ACC = 2'd2
  } mul_lim_t;

  // Request to the shared multiplier
  typedef struct packed {
    logic signed [63:0] a;
    logic signed [63:0] b;
    mul_shift_t         shift;
    mul_lim_t           lim;
  } mul_req_t;

  // Steps of the per-request sequence
  typedef enum logic [3:0] {
    OP_DXSQ = 4'd0,
    OP_CX   = 4'd1,
    OP_DYSQ = 4'd2,
    OP_CY   = 4'd3,
    OP_RCP  = 4'd4,
    OP_XPOS = 4'd5,
    OP_YPOS = 4'd6,
    OP_FXSQ = 4'd7,
    OP_FYSQ = 4'd8,
    OP_GXY  = 4'd9,
    OP_AP   = 4'd10,
    OP_TX   = 4'd11,
    OP_TY   = 4'd12,
    OP_QT   = 4'd13,
    OP_NV   = 4'd14,
    OP_SQ   = 4'd15
  } op_t;

  // Saturate a 64-bit value to the signed grid value range
  function automatic logic signed [VALUE_BITS-1:0] sat_value(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return hi[VALUE_BITS-1:0];
    end else if (v < lo) begin
      return lo[VALUE_BITS-1:0];
    end
    return v[VALUE_BITS-1:0];
  endfunction

endpackage

>>> rtl/core/jsr_line_mem.sv
// Line buffer store: each entry holds {upper line, middle line} for one column
module jsr_line_mem #(
  parameter int DEPTH = jsr_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [63:0]              rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [63:0]              wr_data
);

  logic [63:0] mem_r [DEPTH];
  logic [63:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/jsr_mul.sv
// Shared sign-magnitude multiplier: 64x64 from four 32x32 partial products,
// then truncating shift and magnitude limit.
module jsr_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  jsr_pkg::mul_req_t   req,
  output logic                done,
  output logic signed [63:0]  result
);

  logic [63:0]          ma_r;
  logic [63:0]          mb_r;
  logic                 neg_r;
  jsr_pkg::mul_shift_t  shift_r;
  jsr_pkg::mul_lim_t    lim_r;
  logic [2:0]           cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [63:0]          pp_r;
  logic [127:0]         acc_r;
  logic signed [63:0]   res_r;

  logic [63:0]  abs_a;
  logic [63:0]  abs_b;
  logic [31:0]  op_a;
  logic [31:0]  op_b;
  logic [127:0] pp_sh;
  logic [127:0] shifted;
  logic [63:0]  lim_v;
  logic [63:0]  mag;

  assign abs_a = req.a[63] ? $unsigned(-req.a) : $unsigned(req.a);
  assign abs_b = req.b[63] ? $unsigned(-req.b) : $unsigned(req.b);

  // Partial product operand select
  always_comb begin
    unique case (cnt_r[1:0])
      2'd0: begin op_a = ma_r[31:0];  op_b = mb_r[31:0];  end
      2'd1: begin op_a = ma_r[31:0];  op_b = mb_r[63:32]; end
      2'd2: begin op_a = ma_r[63:32]; op_b = mb_r[31:0];  end
      default: begin op_a = ma_r[63:32]; op_b = mb_r[63:32]; end
    endcase
  end

  // Align the registered partial product of the previous step
  always_comb begin
    unique case (cnt_r)
      3'd1:       pp_sh = {64'd0, pp_r};
      3'd2, 3'd3: pp_sh = {32'd0, pp_r, 32'd0};
      3'd4:       pp_sh = {pp_r, 64'd0};
      default:    pp_sh = '0;
    endcase
  end

  // Truncate and limit
  always_comb begin
    unique case (shift_r)
      jsr_pkg::SH_24: shifted = acc_r >> 24;
      jsr_pkg::SH_35: shifted = acc_r >> 35;
      default:        shifted = acc_r;
    endcase
    unique case (lim_r)
      jsr_pkg::LIM_Q32: lim_v = 64'h0000_0000_7FFF_FFFF;
      jsr_pkg::LIM_BIG: lim_v = 64'h4000_0000_0000_0000;
      default:          lim_v = 64'h7FFF_FFFF_FFFF_FFFF;
    endcase
    mag = ((|shifted[127:64]) || (shifted[63:0] > lim_v)) ? lim_v : shifted[63:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      ma_r    <= abs_a;
      mb_r    <= abs_b;
      neg_r   <= req.a[63] ^ req.b[63];
      shift_r <= req.shift;
      lim_r   <= req.lim;
      acc_r   <= '0;
    end else if (busy_r) begin
      pp_r  <= op_a * op_b;
      acc_r <= acc_r + pp_sh;
      if (cnt_r == 3'd5) begin
        res_r <= neg_r ? -$signed(mag) : $signed(mag);
      end
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

>>> rtl/core/jsr_recip.sv
// Restoring divider for min(limit, floor(2^k / d)), one quotient bit a cycle
module jsr_recip (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [6:0]  k,
  input  logic [62:0] divisor,
  output logic        done,
  output logic [47:0] quotient
);

  logic [62:0] d_r;
  logic [62:0] rem_r;
  logic [47:0] q_r;
  logic        sat_r;
  logic        first_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  logic [63:0] rsh;
  logic        ge;
  logic [63:0] diff;
  logic [62:0] rem_nxt;
  logic [48:0] q_nxt;
  logic        over;

  // One restoring step; the numerator is a single leading one
  always_comb begin
    rsh     = {rem_r, first_r};
    ge      = rsh >= {1'b0, d_r};
    diff    = rsh - {1'b0, d_r};
    rem_nxt = ge ? diff[62:0] : rsh[62:0];
    q_nxt   = {q_r, ge};
    over    = q_nxt > {1'b0, jsr_pkg::COEF_LIM};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= k;
      end else if (busy_r) begin
        if (cnt_r == 7'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r     <= divisor;
      rem_r   <= '0;
      q_r     <= '0;
      sat_r   <= (divisor == 63'd0);
      first_r <= 1'b1;
    end else if (busy_r) begin
      rem_r   <= rem_nxt;
      q_r     <= q_nxt[47:0];
      sat_r   <= sat_r | over;
      first_r <= 1'b0;
    end
  end

  assign done     = done_r;
  assign quotient = sat_r ? jsr_pkg::COEF_LIM : q_r;

endmodule

>>> rtl/core/jacobi_stencil_relaxation.sv
// Over-relaxed Jacobi sweep of the screened Poisson five-point stencil. Grid
// values of the previous iterate enter in raster order, boundary included; one
// result leaves for each interior point, when the value to its lower right is
// taken, with the running saturating sum of squared updates and a flag on the
// last interior point of the frame. Requests are handled one at a time. An
// interior request runs eleven multiplications through one shared 32x32-based
// multiplier. The first request of a frame also forms the coefficients: two
// squares and three reciprocals in a bit-serial divider (73, 73 and 60 steps).
// The two line buffers live in one memory of MAX_WIDTH entries, read once
// and written once per request; entries never written read as anything.
// Configuration may be written whenever no request is in progress; the
// coefficients from spacings and alpha are formed at the next frame start,
// while positions and the source term use the registers directly.
module jacobi_stencil_relaxation #(
  parameter int MAX_WIDTH = jsr_pkg::MAX_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_old_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_new_value,
  output logic [62:0]         out_residual_sum,
  output logic                out_frame_done
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = ((CW + 1) > 11) ? (CW + 1) : 11;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  // Configuration registers
  logic [10:0]        grid_width_r;
  logic [15:0]        grid_height_r;
  logic signed [31:0] x_start_r;
  logic signed [31:0] y_start_r;
  logic [30:0]        delta_x_r;
  logic [30:0]        delta_y_r;
  logic [30:0]        alpha_r;
  logic [25:0]        omega_r;

  // Sequencer and position
  state_t         state_r, state_nxt;
  jsr_pkg::op_t   op_r;
  logic [CW-1:0]  col_cnt_r;
  logic [15:0]    row_cnt_r;
  logic [CW-1:0]  c_r;
  logic [CW-1:0]  col_r;
  logic [15:0]    row_r;
  logic           interior_r;
  logic           last_r;
  logic signed [31:0] v_r;

  // Window taps and coefficients
  logic signed [31:0] n_tap_r, w_tap_r, c_tap_r, s_tap_r;
  logic [47:0]        cx_r, cy_r, rcp_r;
  logic [62:0]        dsq_r;

  // Working values
  logic signed [31:0] fx_r, fy_r, gx_r, gy_r, p_r, f_r, nv_r;
  logic signed [63:0] t_r, upd_r;
  logic [62:0]        acc_r;

  // Result register
  logic               out_valid_r;
  logic signed [31:0] out_new_value_r;
  logic [62:0]        out_residual_r;
  logic               out_frame_done_r;

  // Accept-time decode
  logic           accept;
  logic [WW-1:0]  gw_ext, wcl, c_ext;
  logic [15:0]    hcl;
  logic           wrap;
  logic [CW-1:0]  c_eff;
  logic [15:0]    r_eff;
  logic           c_end, r_end, last, interior, frame_start;

  // Units
  logic               mul_start, mul_done;
  jsr_pkg::mul_req_t  mul_req;
  logic signed [63:0] m;
  logic               div_start, div_done;
  logic [6:0]         div_k;
  logic [62:0]        div_d;
  logic [47:0]        q;
  logic               is_div, unit_done;
  logic [50:0]        ncc_sum;
  logic [46:0]        ncc;

  // Line buffer
  logic [63:0]        rd_data;
  logic signed [31:0] up_v, mid_v;
  logic signed [32:0] we_sum, ns_sum;
  logic               emit_go;
  logic [63:0]        acc_sum;

  assign accept = in_valid && in_ready;
  assign up_v   = rd_data[63:32];
  assign mid_v  = rd_data[31:0];
  assign we_sum = 33'(w_tap_r) + 33'(mid_v);
  assign ns_sum = 33'(n_tap_r) + 33'(s_tap_r);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= 11'd1024;
      grid_height_r <= 16'd1024;
      x_start_r     <= -32'sd16777216;
      y_start_r     <= -32'sd16777216;
      delta_x_r     <= 31'd32768;
      delta_y_r     <= 31'd32768;
      alpha_r       <= 31'd16777216;
      omega_r       <= 26'd16777216;
    end else if (cfg_we) begin
      unique case (jsr_pkg::cfg_reg_t'(cfg_index))
        jsr_pkg::REG_GRID_WIDTH:  grid_width_r  <= cfg_data[10:0];
        jsr_pkg::REG_GRID_HEIGHT: grid_height_r <= cfg_data[15:0];
        jsr_pkg::REG_X_START:     x_start_r     <= cfg_data;
        jsr_pkg::REG_Y_START:     y_start_r     <= cfg_data;
        jsr_pkg::REG_DELTA_X:     delta_x_r     <= cfg_data[30:0];
        jsr_pkg::REG_DELTA_Y:     delta_y_r     <= cfg_data[30:0];
        jsr_pkg::REG_ALPHA:       alpha_r       <= cfg_data[30:0];
        jsr_pkg::REG_OMEGA:       omega_r       <= cfg_data[25:0];
      endcase
    end
  end

  // Clamp geometry and locate the incoming value
  always_comb begin
    gw_ext = WW'(grid_width_r);
    if (gw_ext < WW'(3)) begin
      wcl = WW'(3);
    end else if (gw_ext > WW'(MAX_WIDTH)) begin
      wcl = WW'(MAX_WIDTH);
    end else begin
      wcl = gw_ext;
    end
    hcl         = (grid_height_r < 16'd3) ? 16'd3 : grid_height_r;
    wrap        = (WW'(col_cnt_r) >= wcl) || (row_cnt_r >= hcl);
    c_eff       = wrap ? '0 : col_cnt_r;
    r_eff       = wrap ? '0 : row_cnt_r;
    c_ext       = WW'(c_eff);
    c_end       = (c_ext + WW'(1)) >= wcl;
    r_end       = (17'(r_eff) + 17'd1) >= 17'(hcl);
    last        = (c_ext == wcl - WW'(1)) && (r_eff == hcl - 16'd1);
    interior    = (c_eff >= CW'(2)) && (r_eff >= 16'd2);
    frame_start = (c_eff == '0) && (r_eff == '0);
  end

  // Normalizer 2cx + 2cy + alpha
  always_comb begin
    ncc_sum = {2'b0, cx_r, 1'b0} + {2'b0, cy_r, 1'b0} + 51'(alpha_r);
    ncc     = (ncc_sum > 51'(jsr_pkg::NCC_LIM)) ? jsr_pkg::NCC_LIM : ncc_sum[46:0];
  end

  // Operands for the current step
  always_comb begin
    mul_req = '{a: '0, b: '0, shift: jsr_pkg::SH_0, lim: jsr_pkg::LIM_ACC};
    div_k   = 7'd72;
    div_d   = dsq_r;
    is_div  = 1'b0;
    unique case (op_r)
      jsr_pkg::OP_DXSQ: mul_req = '{{33'd0, delta_x_r}, {33'd0, delta_x_r},
                                    jsr_pkg::SH_0, jsr_pkg::LIM_ACC};
      jsr_pkg::OP_DYSQ: mul_req = '{{33'd0, delta_y_r}, {33'd0, delta_y_r},
                                    jsr_pkg::SH_0, jsr_pkg::LIM_ACC};
      jsr_pkg::OP_CX, jsr_pkg::OP_CY: is_div = 1'b1;
      jsr_pkg::OP_RCP: begin
        is_div = 1'b1;
        div_k  = 7'd59;
        div_d  = 63'(ncc);
      end
      jsr_pkg::OP_XPOS: mul_req = '{64'(col_r), {33'd0, delta_x_r},
                                    jsr_pkg::SH_0, jsr_pkg::LIM_ACC};
      jsr_pkg::OP_YPOS: mul_req = '{64'(row_r), {33'd0, delta_y_r},
                                    jsr_pkg::SH_0, jsr_pkg::LIM_ACC};
      jsr_pkg::OP_FXSQ: mul_req = '{64'(fx_r), 64'(fx_r), jsr_pkg::SH_24, jsr_pkg::LIM_Q32};
      jsr_pkg::OP_FYSQ: mul_req = '{64'(fy_r), 64'(fy_r), jsr_pkg::SH_24, jsr_pkg::LIM_Q32};
      jsr_pkg::OP_GXY:  mul_req = '{64'(gx_r), 64'(gy_r), jsr_pkg::SH_24, jsr_pkg::LIM_Q32};
      jsr_pkg::OP_AP:   mul_req = '{{33'd0, alpha_r}, 64'(p_r),
                                    jsr_pkg::SH_24, jsr_pkg::LIM_Q32};
      jsr_pkg::OP_TX:   mul_req = '{64'(we_sum), {16'd0, cx_r},
                                    jsr_pkg::SH_24, jsr_pkg::LIM_BIG};
      jsr_pkg::OP_TY:   mul_req = '{64'(ns_sum), {16'd0, cy_r},
                                    jsr_pkg::SH_24, jsr_pkg::LIM_BIG};
      jsr_pkg::OP_QT:   mul_req = '{t_r, {16'd0, rcp_r}, jsr_pkg::SH_35, jsr_pkg::LIM_BIG};
      jsr_pkg::OP_NV:   mul_req = '{upd_r, {38'd0, omega_r},
                                    jsr_pkg::SH_24, jsr_pkg::LIM_BIG};
      jsr_pkg::OP_SQ:   mul_req = '{upd_r, upd_r, jsr_pkg::SH_24, jsr_pkg::LIM_ACC};
    endcase
  end

  assign mul_start = (state_r == S_ISSUE) && !is_div;
  assign div_start = (state_r == S_ISSUE) && is_div;
  assign unit_done = is_div ? div_done : mul_done;
  assign emit_go   = (state_r == S_EMIT) && (!interior_r || !out_valid_r || out_ready);
  assign acc_sum   = {1'b0, acc_r} + {1'b0, m[62:0]};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (frame_start || interior) ? S_ISSUE : S_EMIT;
        end
      end
      S_ISSUE: state_nxt = S_WAIT;
      S_WAIT: begin
        if (unit_done) begin
          if (op_r == jsr_pkg::OP_SQ || (op_r == jsr_pkg::OP_RCP && !interior_r)) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_ISSUE;
          end
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= jsr_pkg::OP_DXSQ;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      n_tap_r     <= '0;
      w_tap_r     <= '0;
      c_tap_r     <= '0;
      s_tap_r     <= '0;
      cx_r        <= '0;
      cy_r        <= '0;
      rcp_r       <= '0;
      acc_r       <= '0;
    end else begin
      state_r <= state_nxt;
      // New request: advance raster position
      if (accept) begin
        col_cnt_r <= c_end ? '0 : c_eff + CW'(1);
        row_cnt_r <= c_end ? (r_end ? 16'd0 : r_eff + 16'd1) : r_eff;
        op_r      <= frame_start ? jsr_pkg::OP_DXSQ : jsr_pkg::OP_XPOS;
        if (frame_start) begin
          acc_r <= '0;
        end
      end
      // Step results
      if (state_r == S_WAIT && unit_done) begin
        op_r <= jsr_pkg::op_t'(op_r + 4'd1);
        unique case (op_r)
          jsr_pkg::OP_CX:  cx_r  <= q;
          jsr_pkg::OP_CY:  cy_r  <= q;
          jsr_pkg::OP_RCP: rcp_r <= q;
          jsr_pkg::OP_SQ:  acc_r <= acc_sum[63] ? '1 : acc_sum[62:0];
          default: ;
        endcase
      end
      // Retire: shift the window, present the result
      if (emit_go) begin
        w_tap_r <= c_tap_r;
        c_tap_r <= mid_v;
        n_tap_r <= up_v;
        s_tap_r <= v_r;
      end
      if (emit_go && interior_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept) begin
      c_r        <= c_eff;
      col_r      <= c_eff - CW'(2);
      row_r      <= r_eff - 16'd2;
      interior_r <= interior;
      last_r     <= last;
      v_r        <= in_old_value;
    end
    if (state_r == S_WAIT && unit_done) begin
      unique case (op_r)
        jsr_pkg::OP_DXSQ, jsr_pkg::OP_DYSQ: dsq_r <= m[62:0];
        jsr_pkg::OP_XPOS: fx_r <= jsr_pkg::sat_value(64'(x_start_r) + m);
        jsr_pkg::OP_YPOS: fy_r <= jsr_pkg::sat_value(64'(y_start_r) + m);
        jsr_pkg::OP_FXSQ: gx_r <= jsr_pkg::sat_value(jsr_pkg::ONE_Q24 - m);
        jsr_pkg::OP_FYSQ: gy_r <= jsr_pkg::sat_value(jsr_pkg::ONE_Q24 - m);
        jsr_pkg::OP_GXY:  p_r  <= m[31:0];
        jsr_pkg::OP_AP:   f_r  <= jsr_pkg::sat_value(-m - 64'(gx_r) - 64'(gx_r)
                                                     - 64'(gy_r) - 64'(gy_r));
        jsr_pkg::OP_TX:   t_r  <= m;
        jsr_pkg::OP_TY:   t_r  <= t_r + m - 64'(f_r);
        jsr_pkg::OP_QT:   upd_r <= 64'(c_tap_r) - m;
        jsr_pkg::OP_NV:   nv_r <= jsr_pkg::sat_value(64'(c_tap_r) - m);
        default: ;
      endcase
    end
    if (emit_go && interior_r) begin
      out_new_value_r  <= nv_r;
      out_residual_r   <= acc_r;
      out_frame_done_r <= last_r;
    end
  end

  jsr_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (c_eff),
    .rd_data (rd_data),
    .wr_en   (emit_go),
    .wr_addr (c_r),
    .wr_data ({mid_v, v_r})
  );

  jsr_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .req    (mul_req),
    .done   (mul_done),
    .result (m)
  );

  jsr_recip u_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .k        (div_k),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (q)
  );

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_new_value    = out_new_value_r;
  assign out_residual_sum = out_residual_r;
  assign out_frame_done   = out_frame_done_r;

endmodule

>>> rtl/core/jsr_checker.sv
// Port-level checks
module jsr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_new_value,
  input logic [62:0] out_residual_sum,
  input logic        out_frame_done
);

  // Requests taken but not yet answered, saturating
  logic [31:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (pend_r != '1) begin
      pend_r <= pend_r + 32'(in_valid && in_ready) - 32'(out_valid && out_ready);
    end
  end

  // A result never appears without a request behind it
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 32'd0)
    else $error("result without request");

  // One request in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // Reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_value)
      && $stable(out_residual_sum) && $stable(out_frame_done))
    else $error("stalled result changed");

endmodule

bind jacobi_stencil_relaxation jsr_checker u_jsr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_new_value    (out_new_value),
  .out_residual_sum (out_residual_sum),
  .out_frame_done   (out_frame_done)
);

>>> verif/jacobi_stencil_relaxation_tb.sv
`timescale 1ns / 100ps

module jacobi_stencil_relaxation_tb;

  localparam int LINE_DEPTH = 1024;
  localparam longint Q32_HI = 64'sd2147483647;
  localparam logic [63:0] BIG_LIM = 64'd1 << 62;
  localparam logic [63:0] ACC_LIM = (64'd1 << 63) - 64'd1;
  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    logic signed [31:0] new_value;
    logic [62:0]        residual_sum;
    logic               frame_done;
  } stencil_result_t;

  typedef struct {
    logic signed [31:0] old_value;
    bit                 typed;
    logic signed [31:0] center;
  } grid_row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_old_value;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_new_value;
  logic [62:0]        out_residual_sum;
  logic               out_frame_done;

  jacobi_stencil_relaxation dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_old_value(in_old_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_new_value(out_new_value),
    .out_residual_sum(out_residual_sum), .out_frame_done(out_frame_done)
  );

  // Predictor state: configuration copy
  int     cur_width, cur_height;
  longint cur_x0, cur_y0, cur_dx, cur_dy, cur_alpha, cur_omega;
  // Predictor state: line buffers, window, raster position, frame coefficients
  longint line_above [LINE_DEPTH];
  longint line_mid [LINE_DEPTH];
  longint tap_n, tap_w, tap_c, tap_s, tap_e;
  int     col_pos, row_pos;
  logic [63:0] residual_run;
  longint coef_x, coef_y, coef_ncc, coef_rcp;

  stencil_result_t pending_results[$];
  int fail_count;
  int idle_pct, stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sign * min(lim, (|a|*|b|) >> sh)
  function automatic longint mul_sat(longint a, longint b, int sh, logic [63:0] lim);
    logic [63:0]  ma, mb;
    logic [127:0] prod;
    ma = (a < 0) ? (64'd0 - 64'(a)) : 64'(a);
    mb = (b < 0) ? (64'd0 - 64'(b)) : 64'(b);
    prod = ({64'd0, ma} * {64'd0, mb}) >> sh;
    if (prod > {64'd0, lim}) prod = {64'd0, lim};
    return ((a < 0) != (b < 0)) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic longint clamp_sym(longint v, longint hi);
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // min(lim, floor(2^k / d)); zero divisor saturates
  function automatic longint recip_sat(int k, logic [63:0] d, logic [63:0] lim);
    logic [127:0] q;
    if (d == 64'd0) return longint'(lim);
    q = (128'd1 << k) / {64'd0, d};
    if (q > {64'd0, lim}) return longint'(lim);
    return longint'(q[63:0]);
  endfunction

  function automatic longint source_at(int gx_idx, int gy_idx);
    longint px, py, gx, gy, prod, ap;
    px = clamp_sym(cur_x0 + longint'(gx_idx) * cur_dx, Q32_HI);
    py = clamp_sym(cur_y0 + longint'(gy_idx) * cur_dy, Q32_HI);
    gx = clamp_sym(jsr_pkg::ONE_Q24 - mul_sat(px, px, 24, 64'(Q32_HI)), Q32_HI);
    gy = clamp_sym(jsr_pkg::ONE_Q24 - mul_sat(py, py, 24, 64'(Q32_HI)), Q32_HI);
    prod = mul_sat(gx, gy, 24, 64'(Q32_HI));
    ap = mul_sat(cur_alpha, prod, 24, 64'(Q32_HI));
    return clamp_sym(-ap - 2 * gx - 2 * gy, Q32_HI);
  endfunction

  // Advance the predictor by one grid value; returns 1 when a point is updated
  function automatic bit relax_point(logic signed [31:0] value, output stencil_result_t res);
    int w, h, c, r;
    longint v, up, mid, f, t, q, upd, nv, ncc;
    logic [63:0] sq;
    bit produced;
    produced = 1'b0;
    res = '{default: '0};
    w = (cur_width < 3) ? 3 : ((cur_width > LINE_DEPTH) ? LINE_DEPTH : cur_width);
    h = (cur_height < 3) ? 3 : cur_height;
    if (col_pos >= w || row_pos >= h) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    // frame start: latch coefficients from current spacings and alpha
    if (c == 0 && r == 0) begin
      coef_x = recip_sat(72, 64'(cur_dx * cur_dx), 64'(jsr_pkg::COEF_LIM));
      coef_y = recip_sat(72, 64'(cur_dy * cur_dy), 64'(jsr_pkg::COEF_LIM));
      ncc = 2 * coef_x + 2 * coef_y + cur_alpha;
      if (ncc > longint'(jsr_pkg::NCC_LIM)) ncc = longint'(jsr_pkg::NCC_LIM);
      coef_ncc = ncc;
      coef_rcp = recip_sat(59, 64'(ncc), 64'(jsr_pkg::COEF_LIM));
      residual_run = 64'd0;
    end
    v = longint'(value);
    up = line_above[c];
    mid = line_mid[c];
    tap_e = mid;
    if (r >= 2 && c >= 2) begin
      f = source_at(c - 2, r - 2);
      t = mul_sat(tap_w + tap_e, coef_x, 24, BIG_LIM)
        + mul_sat(tap_n + tap_s, coef_y, 24, BIG_LIM) - f;
      q = mul_sat(t, coef_rcp, 35, BIG_LIM);
      upd = tap_c - q;
      nv = clamp_sym(tap_c - mul_sat(upd, cur_omega, 24, BIG_LIM), Q32_HI);
      sq = 64'(mul_sat(upd, upd, 24, ACC_LIM));
      residual_run = (sq > ACC_LIM - residual_run) ? ACC_LIM : residual_run + sq;
      res.new_value = nv[31:0];
      res.residual_sum = residual_run[62:0];
      res.frame_done = (c == w - 1 && r == h - 1);
      produced = 1'b1;
    end
    tap_w = tap_c;
    tap_c = mid;
    tap_n = up;
    tap_s = v;
    line_above[c] = mid;
    line_mid[c] = v;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
    return produced;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    $display("%0t MISMATCH %s: expected %0h got %0h", $realtime, what, want, got);
    fail_count++;
  endtask

  // Result side: compare and stall at random
  always @(posedge clk) begin
    stencil_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 64'd0, 64'(out_new_value));
        end else begin
          want = pending_results.pop_front();
          if (out_new_value !== want.new_value)
            report_mismatch("new_value", 64'(want.new_value), 64'(out_new_value));
          if (out_residual_sum !== want.residual_sum)
            report_mismatch("residual_sum", 64'(want.residual_sum), 64'(out_residual_sum));
          if (out_frame_done !== want.frame_done)
            report_mismatch("frame_done", 64'(want.frame_done), 64'(out_frame_done));
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Config write; caller lowers cfg_we after the batch
  task automatic cfg_write(jsr_pkg::cfg_reg_t idx, logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    case (idx)
      jsr_pkg::REG_GRID_WIDTH:  cur_width = int'(d[10:0]);
      jsr_pkg::REG_GRID_HEIGHT: cur_height = int'(d[15:0]);
      jsr_pkg::REG_X_START:     cur_x0 = longint'($signed(d));
      jsr_pkg::REG_Y_START:     cur_y0 = longint'($signed(d));
      jsr_pkg::REG_DELTA_X:     cur_dx = longint'(d[30:0]);
      jsr_pkg::REG_DELTA_Y:     cur_dy = longint'(d[30:0]);
      jsr_pkg::REG_ALPHA:       cur_alpha = longint'(d[30:0]);
      jsr_pkg::REG_OMEGA:       cur_omega = longint'(d[25:0]);
      default: ;
    endcase
  endtask

  task automatic load_setup(logic [31:0] w, logic [31:0] h, logic [31:0] x0, logic [31:0] y0,
                            logic [31:0] dx, logic [31:0] dy, logic [31:0] al,
                            logic [31:0] om);
    cfg_write(jsr_pkg::REG_GRID_WIDTH, w);
    cfg_write(jsr_pkg::REG_GRID_HEIGHT, h);
    cfg_write(jsr_pkg::REG_X_START, x0);
    cfg_write(jsr_pkg::REG_Y_START, y0);
    cfg_write(jsr_pkg::REG_DELTA_X, dx);
    cfg_write(jsr_pkg::REG_DELTA_Y, dy);
    cfg_write(jsr_pkg::REG_ALPHA, al);
    cfg_write(jsr_pkg::REG_OMEGA, om);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Send one grid value; optionally override the expected new_value
  task automatic send_value(logic signed [31:0] v, bit typed, logic signed [31:0] center);
    stencil_result_t res;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_old_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (relax_point(v, res)) begin
      if (typed) res.new_value = center;
      pending_results.push_back(res);
    end
  endtask

  // Wait out every result plus any boundary work still in flight
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    if ($urandom_range(1)) return $urandom;
    return 32'($signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
  endfunction

  function automatic logic [31:0] rand_scale();
    if ($urandom_range(1)) return $urandom_range(32'h7FFF_FFFF, 1);
    return $urandom_range(32'h0040_0000, 32'h0000_4000);
  endfunction

  // Directed rows: omega zero leaves the center unchanged
  grid_row_t directed_rows[18] = '{
    '{32'h7FFF_FFFF, 1'b0, 32'h0}, '{32'h8000_0000, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b0, 32'h0}, '{32'h8000_0000, 1'b0, 32'h0},
    '{32'h1234_5678, 1'b0, 32'h0}, '{32'h7FFF_FFFF, 1'b0, 32'h0},
    '{32'h0000_0001, 1'b0, 32'h0}, '{32'hFFFF_FFFF, 1'b0, 32'h0},
    '{32'h5555_5555, 1'b1, 32'h1234_5678},
    '{32'hAAAA_AAAA, 1'b0, 32'h0}, '{32'h7FFF_FFFF, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b0, 32'h0}, '{32'h0100_0000, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b0, 32'h0}, '{32'hFF00_0000, 1'b0, 32'h0},
    '{32'h7FFF_FFFF, 1'b0, 32'h0}, '{32'h0000_0000, 1'b0, 32'h0},
    '{32'h8000_0001, 1'b1, 32'h8000_0000}
  };

  initial begin
    int w, h, n;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 3'd0;
    cfg_data = 32'd0;
    in_valid = 1'b0;
    in_old_value = 32'sd0;
    out_ready = 1'b0;
    fail_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    // predictor reset
    cur_width = 1024;
    cur_height = 1024;
    cur_x0 = -16777216;
    cur_y0 = -16777216;
    cur_dx = 32768;
    cur_dy = 32768;
    cur_alpha = 16777216;
    cur_omega = 16777216;
    foreach (line_above[i]) begin
      line_above[i] = 0;
      line_mid[i] = 0;
    end
    tap_n = 0; tap_w = 0; tap_c = 0; tap_s = 0; tap_e = 0;
    col_pos = 0;
    row_pos = 0;
    residual_run = 64'd0;
    coef_x = 0; coef_y = 0; coef_ncc = 0; coef_rcp = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: two 3x3 frames with no relaxation
    load_setup(32'd3, 32'd3, 32'hFF00_0000, 32'hFF00_0000, 32'h0000_8000, 32'h0000_8000,
               32'h0100_0000, 32'd0);
    foreach (directed_rows[i])
      send_value(directed_rows[i].old_value, directed_rows[i].typed, directed_rows[i].center);
    drain();

    // Directed: extreme spacings, alpha and omega
    load_setup(32'd3, 32'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h0200_0000);
    foreach (directed_rows[i]) if (i < 9) send_value(directed_rows[i].old_value, 1'b0, 0);
    drain();

    // Zero width clamps to 3; tallest height, left mid-frame
    load_setup(32'd0, 32'd65535, 32'd0, 32'd0, 32'h0100_0000, 32'h0080_0000, 32'd0,
               32'h0180_0000);
    repeat (12) send_value(rand_value(), 1'b0, 0);
    drain();

    // Oversized width clamps to the full line; zero height clamps to 3
    load_setup(32'd2047, 32'd0, 32'hFFF0_0000, 32'h0010_0000, 32'h0000_1000, 32'h0000_2000,
               32'h0000_0100, 32'h0100_0000);
    repeat (40) send_value(rand_value(), 1'b0, 0);
    drain();

    // Random phases, cycling the idle patterns, whole frames each
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      w = $urandom_range(8, 3);
      h = $urandom_range(6, 3);
      load_setup(w, h, $urandom_range(1) ? $urandom : rand_value(),
                 $urandom_range(1) ? $urandom : rand_value(),
                 rand_scale(), rand_scale(), $urandom_range(1) ? rand_scale() : 32'd0,
                 $urandom_range(32'h0200_0000, 0));
      n = 0;
      while (n < 30) begin
        repeat (w * h) send_value(rand_value(), 1'b0, 0);
        n += w * h;
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Run limit
  initial begin
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/jsr_pkg.sv
rtl/core/jsr_line_mem.sv
rtl/core/jsr_mul.sv
rtl/core/jsr_recip.sv
rtl/core/jacobi_stencil_relaxation.sv
rtl/core/jsr_checker.sv
verif/jacobi_stencil_relaxation_tb.sv
